>>> hw/rtl/slsd_pkg.sv
// Package for the static-list symmetric-difference block: types, codes and the microcode table.
`timescale 1ns / 1ps
package slsd_pkg;

	localparam int SLSD_CAPACITY   = 64;
	localparam int SLSD_DATA_WIDTH = 32;
	localparam int HEAD_SLOT       = 1;
	localparam int FIRST_FREE      = 2;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_TOGGLE = 2'd2;
	localparam logic [1:0] ACT_DUMP   = 2'd3;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_REMOVED  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_ELEMENT  = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] item_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] element_value;
		logic               last;
	} rsp_t;

	typedef enum logic [3:0] {
		U_IDLE       = 4'd0,
		U_RST_SWEEP  = 4'd1,
		U_CLR_SWEEP  = 4'd2,
		U_CLR_DONE   = 4'd3,
		U_APP_RD     = 4'd4,
		U_APP_WR     = 4'd5,
		U_APP_LINK   = 4'd6,
		U_APP_FULL   = 4'd7,
		U_TGL_FIRST  = 4'd8,
		U_TGL_WALK   = 4'd9,
		U_TGL_UNLINK = 4'd10,
		U_TGL_FREE   = 4'd11,
		U_DMP_FIRST  = 4'd12,
		U_DMP_WALK   = 4'd13,
		U_DMP_EMPTY  = 4'd14
	} upc_t;

	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_ALWAYS     = 3'd1,
		C_ACCEPT     = 3'd2,
		C_LINK_ZERO  = 3'd3,
		C_MATCH      = 3'd4,
		C_FREE_EMPTY = 3'd5,
		C_SWEEP_END  = 3'd6
	} cond_t;

	typedef enum logic [1:0] {
		ADV_NO      = 2'd0,
		ADV_YES     = 2'd1,
		ADV_NOMATCH = 2'd2
	} adv_t;

	typedef enum logic [2:0] {
		OP_NONE      = 3'd0,
		OP_SWEEP     = 3'd1,
		OP_ALLOC     = 3'd2,
		OP_LINK_TAIL = 3'd3,
		OP_BYPASS    = 3'd4,
		OP_RELEASE   = 3'd5,
		OP_REINIT    = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		EM_NONE    = 3'd0,
		EM_APPEND  = 3'd1,
		EM_FULL    = 3'd2,
		EM_REMOVED = 3'd3,
		EM_ELEMENT = 3'd4,
		EM_EMPTY   = 3'd5,
		EM_CLEARED = 3'd6
	} emit_t;

	typedef struct packed {
		logic  take_input;
		cond_t cond_a;
		upc_t  tgt_a;
		cond_t cond_b;
		upc_t  tgt_b;
		logic  stay;
		adv_t  adv;
		logic  rd_free;
		op_t   op;
		emit_t emit;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		logic   stall;
		logic   accept;
	} ctl_t;

	typedef struct packed {
		logic link_zero;
		logic match;
		logic free_empty;
		logic sweep_end;
	} dp_flags_t;

	// Entry step of each action's routine.
	function automatic upc_t dispatch_target(input logic [1:0] action);
		upc_t t;
		case (action)
			ACT_CLEAR:  t = U_CLR_SWEEP;
			ACT_APPEND: t = U_APP_RD;
			ACT_TOGGLE: t = U_TGL_FIRST;
			default:    t = U_DMP_FIRST;
		endcase
		return t;
	endfunction

	function automatic uword_t ucode_word(input upc_t upc);
		uword_t w;
		w = '0;
		case (upc)
			U_IDLE: begin
				w.take_input = 1'b1;
				w.cond_a     = C_ACCEPT;
				w.stay       = 1'b1;
			end
			U_RST_SWEEP: begin
				w.op     = OP_SWEEP;
				w.cond_a = C_SWEEP_END;
				w.tgt_a  = U_IDLE;
				w.stay   = 1'b1;
			end
			U_CLR_SWEEP: begin
				w.op     = OP_SWEEP;
				w.cond_a = C_SWEEP_END;
				w.tgt_a  = U_CLR_DONE;
				w.stay   = 1'b1;
			end
			U_CLR_DONE: begin
				w.op     = OP_REINIT;
				w.emit   = EM_CLEARED;
				w.cond_a = C_ALWAYS;
				w.tgt_a  = U_IDLE;
			end
			U_APP_RD: begin
				w.rd_free = 1'b1;
				w.cond_a  = C_FREE_EMPTY;
				w.tgt_a   = U_APP_FULL;
			end
			U_APP_WR: begin
				w.op = OP_ALLOC;
			end
			U_APP_LINK: begin
				w.op     = OP_LINK_TAIL;
				w.emit   = EM_APPEND;
				w.cond_a = C_ALWAYS;
				w.tgt_a  = U_IDLE;
			end
			U_APP_FULL: begin
				w.emit   = EM_FULL;
				w.cond_a = C_ALWAYS;
				w.tgt_a  = U_IDLE;
			end
			U_TGL_FIRST: begin
				w.adv    = ADV_YES;
				w.cond_a = C_LINK_ZERO;
				w.tgt_a  = U_APP_RD;
			end
			U_TGL_WALK: begin
				w.adv    = ADV_NOMATCH;
				w.cond_a = C_MATCH;
				w.tgt_a  = U_TGL_UNLINK;
				w.cond_b = C_LINK_ZERO;
				w.tgt_b  = U_APP_RD;
				w.stay   = 1'b1;
			end
			U_TGL_UNLINK: begin
				w.op = OP_BYPASS;
			end
			U_TGL_FREE: begin
				w.op     = OP_RELEASE;
				w.emit   = EM_REMOVED;
				w.cond_a = C_ALWAYS;
				w.tgt_a  = U_IDLE;
			end
			U_DMP_FIRST: begin
				w.adv    = ADV_YES;
				w.cond_a = C_LINK_ZERO;
				w.tgt_a  = U_DMP_EMPTY;
			end
			U_DMP_WALK: begin
				w.adv    = ADV_YES;
				w.emit   = EM_ELEMENT;
				w.cond_a = C_LINK_ZERO;
				w.tgt_a  = U_IDLE;
				w.stay   = 1'b1;
			end
			U_DMP_EMPTY: begin
				w.emit   = EM_EMPTY;
				w.cond_a = C_ALWAYS;
				w.tgt_a  = U_IDLE;
			end
			default: begin
				w.cond_a = C_ALWAYS;
				w.tgt_a  = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/slsd_useq.sv
// Microcode sequencer: step counter, control-word fetch and conditional jumps.
`timescale 1ns / 1ps
module slsd_useq
	import slsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic [1:0] action,
	input  logic       emit_ok,
	input  dp_flags_t  flags,
	output ctl_t       ctl
);

	upc_t   upc_q;
	upc_t   upc_next;
	uword_t uw;
	logic   stall;
	logic   accept;

	function automatic logic cond_true(input cond_t c, input logic acc, input dp_flags_t f);
		logic r;
		case (c)
			C_ALWAYS:     r = 1'b1;
			C_ACCEPT:     r = acc;
			C_LINK_ZERO:  r = f.link_zero;
			C_MATCH:      r = f.match;
			C_FREE_EMPTY: r = f.free_empty;
			C_SWEEP_END:  r = f.sweep_end;
			default:      r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		uw     = ucode_word(upc_q);
		accept = uw.take_input && cmd_valid;
		// A step that emits waits until the result register can take it.
		stall  = (uw.emit != EM_NONE) && !emit_ok;
	end

	always_comb begin
		if (stall) begin
			upc_next = upc_q;
		end else if (cond_true(uw.cond_a, accept, flags)) begin
			upc_next = (uw.cond_a == C_ACCEPT) ? dispatch_target(action) : uw.tgt_a;
		end else if (cond_true(uw.cond_b, accept, flags)) begin
			upc_next = uw.tgt_b;
		end else if (uw.stay) begin
			upc_next = upc_q;
		end else begin
			upc_next = upc_t'(upc_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_RST_SWEEP;
		end else begin
			upc_q <= upc_next;
		end
	end

	assign ctl.uw     = uw;
	assign ctl.stall  = stall;
	assign ctl.accept = accept;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> upc_q != U_IDLE)
		else $error("accepted item did not start a routine");

endmodule

>>> hw/rtl/slsd_dpath.sv
// Datapath: link and value memories, list pointers, walk registers and result formatting.
`timescale 1ns / 1ps
module slsd_dpath
	import slsd_pkg::*;
#(
	parameter int CAPACITY   = SLSD_CAPACITY,
	parameter int DATA_WIDTH = SLSD_DATA_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_t      ctl,
	input  cmd_t      cmd,
	output dp_flags_t flags,
	output logic      res_valid,
	output rsp_t      res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam logic [AW-1:0] HEAD      = AW'(HEAD_SLOT);
	localparam logic [AW-1:0] FIRST     = AW'(FIRST_FREE);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	logic [AW-1:0]         link_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];

	logic [AW-1:0]         free_head_q;
	logic [AW-1:0]         tail_q;
	logic [AW-1:0]         cur_q;
	logic [AW-1:0]         prev_q;
	logic [1:0]            act_q;
	logic signed [31:0]    echo_q;
	logic [DATA_WIDTH-1:0] v_q;
	logic [AW-1:0]         link_rd_q;
	logic [DATA_WIDTH-1:0] val_rd_q;

	logic signed [XW-1:0]  in_ext;
	logic [XW-1:0]         rd_ext;
	logic                  go;
	logic                  advance;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  link_we;
	logic [AW-1:0]         link_wa;
	logic [AW-1:0]         link_wd;
	logic                  val_we;
	logic [AW-1:0]         sweep_link;

	assign go = !ctl.stall;

	always_comb begin
		in_ext = XW'(cmd.item_value);
		rd_ext = XW'(val_rd_q);
	end

	always_comb begin
		flags.link_zero  = (link_rd_q == '0);
		flags.match      = (val_rd_q == v_q);
		flags.free_empty = (free_head_q == '0);
		flags.sweep_end  = (cur_q == LAST_SLOT);
	end

	// The head slot and the last slot end their chains; every other slot links to the next.
	always_comb begin
		if (cur_q == HEAD || cur_q == LAST_SLOT) begin
			sweep_link = '0;
		end else begin
			sweep_link = cur_q + 1'b1;
		end
	end

	always_comb begin
		advance = go && ((ctl.uw.adv == ADV_YES) ||
			(ctl.uw.adv == ADV_NOMATCH && !flags.match));
		rd_en   = ctl.accept || (go && ctl.uw.rd_free) || advance;
		if (ctl.accept) begin
			rd_addr = HEAD;
		end else if (ctl.uw.rd_free) begin
			rd_addr = free_head_q;
		end else begin
			rd_addr = link_rd_q;
		end
	end

	always_comb begin
		link_we = 1'b0;
		link_wa = cur_q;
		link_wd = '0;
		case (ctl.uw.op)
			OP_SWEEP: begin
				link_we = go;
				link_wa = cur_q;
				link_wd = sweep_link;
			end
			OP_ALLOC: begin
				link_we = go;
				link_wa = free_head_q;
				link_wd = '0;
			end
			OP_LINK_TAIL: begin
				link_we = go;
				link_wa = tail_q;
				link_wd = cur_q;
			end
			OP_BYPASS: begin
				link_we = go;
				link_wa = prev_q;
				link_wd = link_rd_q;
			end
			OP_RELEASE: begin
				link_we = go;
				link_wa = cur_q;
				link_wd = free_head_q;
			end
			default: begin
				link_we = 1'b0;
			end
		endcase
		val_we = go && (ctl.uw.op == OP_ALLOC);
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (val_we) begin
			val_mem[free_head_q] <= v_q;
		end
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr];
			val_rd_q  <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= FIRST;
			tail_q      <= HEAD;
			cur_q       <= HEAD;
		end else if (ctl.accept) begin
			cur_q <= HEAD;
		end else if (go) begin
			case (ctl.uw.op)
				OP_SWEEP: begin
					cur_q <= cur_q + 1'b1;
				end
				OP_ALLOC: begin
					free_head_q <= link_rd_q;
					cur_q       <= free_head_q;
				end
				OP_LINK_TAIL: begin
					tail_q <= cur_q;
				end
				OP_BYPASS: begin
					if (tail_q == cur_q) begin
						tail_q <= prev_q;
					end
				end
				OP_RELEASE: begin
					free_head_q <= cur_q;
				end
				OP_REINIT: begin
					free_head_q <= FIRST;
					tail_q      <= HEAD;
				end
				default: begin
					if (advance) begin
						cur_q <= link_rd_q;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			act_q  <= cmd.action;
			echo_q <= cmd.item_value;
			v_q    <= in_ext[DATA_WIDTH-1:0];
		end
		if (advance) begin
			prev_q <= cur_q;
		end
	end

	always_comb begin
		res_valid         = (ctl.uw.emit != EM_NONE);
		res.status        = ST_DONE;
		res.element_value = echo_q;
		res.last          = 1'b1;
		case (ctl.uw.emit)
			EM_APPEND: begin
				res.status = (act_q == ACT_TOGGLE) ? ST_INSERTED : ST_DONE;
			end
			EM_FULL: begin
				res.status = ST_FULL;
			end
			EM_REMOVED: begin
				res.status = ST_REMOVED;
			end
			EM_ELEMENT: begin
				res.status        = ST_ELEMENT;
				res.element_value = rd_ext[31:0];
				res.last          = flags.link_zero;
			end
			EM_EMPTY: begin
				res.status        = ST_EMPTY;
				res.element_value = '0;
			end
			default: begin
				res.status = ST_DONE;
			end
		endcase
	end

	a_free_tail_apart: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q != tail_q)
		else $error("free chain head coincides with list tail");

	a_alloc_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.uw.op == OP_ALLOC && go) |-> free_head_q != '0)
		else $error("slot allocated from an empty free chain");

	a_head_never_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.uw.op == OP_BYPASS || ctl.uw.op == OP_RELEASE) |-> cur_q != HEAD)
		else $error("head slot selected for removal");

endmodule

>>> hw/rtl/static_list_symmetric_difference.sv
// Top level of the static-list symmetric-difference block: sequencer, datapath, result register.
// The result of an item is registered and appears on rsp in the cycle after its last microcode step.
// Clear rewrites one link per cycle and then resets the free and tail pointers; append takes a free
// slot or reports full; toggle walks the list one node per cycle and removes the first matching node
// or adds a new one behind the last node; dump returns one result per element, or one when empty.
// A step that emits waits while the result register is held by rsp_ready low.
// One item is in work at a time; the next is taken the cycle after the previous routine ends.
// After reset the sequencer rebuilds the link memory with cmd_ready low.
`timescale 1ns / 1ps
module static_list_symmetric_difference
	import slsd_pkg::*;
#(
	parameter int CAPACITY   = SLSD_CAPACITY,
	parameter int DATA_WIDTH = SLSD_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_t      ctl;
	dp_flags_t flags;
	logic      res_valid;
	rsp_t      res;
	logic      emit_ok;
	logic      rsp_valid_q;
	rsp_t      rsp_q;

	assign emit_ok = !rsp_valid_q || rsp_ready;

	slsd_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.action    (cmd.action),
		.emit_ok   (emit_ok),
		.flags     (flags),
		.ctl       (ctl)
	);

	slsd_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd       (cmd),
		.flags     (flags),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && emit_ok) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && emit_ok) begin
			rsp_q <= res;
		end
	end

	assign cmd_ready = ctl.uw.take_input;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> test/static_list_symmetric_difference_test.sv
// Testbench for the static-list symmetric-difference block: list predictor, directed and random items.
`timescale 1ns / 1ps
module static_list_symmetric_difference_test
	import slsd_pkg::*;
();

	localparam int SLOTS        = SLSD_CAPACITY;
	localparam int SLOT_W       = $clog2(SLSD_CAPACITY);
	localparam int MAX_LISTED   = SLSD_CAPACITY - 2;
	localparam int RANDOM_ITEMS = 225;
	localparam int CALM_FROM    = 195;
	localparam int MAX_FILLS    = 2;

	class list_scoreboard;
		logic [SLOT_W-1:0] link_of [SLOTS];
		logic [31:0]       value_of [SLOTS];
		logic [SLOT_W-1:0] free_slot;
		logic [SLOT_W-1:0] head_slot;
		logic [SLOT_W-1:0] tail_slot;
		rsp_t              expected [$];
		int                errors;

		function new();
			errors = 0;
			foreach (value_of[i]) value_of[i] = '0;
			rebuild_links();
		endfunction

		function void rebuild_links();
			for (int i = 0; i < SLOTS; i++)
				link_of[i] = (i + 1 < SLOTS) ? SLOT_W'(i + 1) : '0;
			head_slot = SLOT_W'(HEAD_SLOT);
			tail_slot = SLOT_W'(HEAD_SLOT);
			free_slot = SLOT_W'(FIRST_FREE);
			link_of[HEAD_SLOT] = '0;
		endfunction

		function void add_expect(logic [2:0] status, logic [31:0] value, logic last);
			rsp_t e;
			e.status        = status;
			e.element_value = value;
			e.last          = last;
			expected.push_back(e);
		endfunction

		// Pops a free slot and links it behind the tail; returns 0 when no slot is left.
		function bit take_slot(logic [31:0] v);
			logic [SLOT_W-1:0] p;
			p = free_slot;
			if (p == '0)
				return 1'b0;
			free_slot   = link_of[p];
			value_of[p] = v;
			link_of[p]  = '0;
			link_of[tail_slot] = p;
			tail_slot   = p;
			return 1'b1;
		endfunction

		function void note_cmd(cmd_t c);
			logic [31:0]       v;
			logic [SLOT_W-1:0] prev;
			logic [SLOT_W-1:0] cur;
			logic [SLOT_W-1:0] nxt;
			int                steps;
			int                n;
			v = c.item_value;
			case (c.action)
				ACT_CLEAR: begin
					rebuild_links();
					add_expect(ST_DONE, v, 1'b1);
				end
				ACT_APPEND: begin
					add_expect(take_slot(v) ? ST_DONE : ST_FULL, v, 1'b1);
				end
				ACT_TOGGLE: begin
					prev  = head_slot;
					cur   = link_of[head_slot];
					steps = 0;
					while (cur != '0 && steps < SLOTS && value_of[cur] != v) begin
						prev = cur;
						cur  = link_of[cur];
						steps++;
					end
					if (cur == '0 || steps >= SLOTS) begin
						add_expect(take_slot(v) ? ST_INSERTED : ST_FULL, v, 1'b1);
					end else begin
						link_of[prev] = link_of[cur];
						link_of[cur]  = free_slot;
						free_slot     = cur;
						if (tail_slot == cur)
							tail_slot = prev;
						add_expect(ST_REMOVED, v, 1'b1);
					end
				end
				default: begin
					n   = 0;
					cur = link_of[head_slot];
					while (cur != '0 && n < MAX_LISTED) begin
						nxt = link_of[cur];
						add_expect(ST_ELEMENT, value_of[cur], (nxt == '0) || (n == MAX_LISTED - 1));
						n++;
						cur = nxt;
					end
					if (n == 0)
						add_expect(ST_EMPTY, '0, 1'b1);
				end
			endcase
		endfunction

		function void check_rsp(rsp_t r);
			rsp_t e;
			if (expected.size() == 0) begin
				$error("result with no item waiting: status %0d, element_value %h, last %0d",
					r.status, r.element_value, r.last);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (r.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, r.status);
				errors++;
			end
			if (r.element_value !== e.element_value) begin
				$error("element_value: expected %h, actual %h", e.element_value, r.element_value);
				errors++;
			end
			if (r.last !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, r.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	list_scoreboard sb = new();
	int  items_sent = 0;
	int  calm_mark  = 32'h7FFF_FFFF;
	bit  calm       = 1'b0;
	int  ready_hold = 0;

	static_list_symmetric_difference dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("static_list_symmetric_difference: mismatch");
		$finish;
	end

	// Result side: check every accepted item, stall ready in short random bursts.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			sb.check_rsp(rsp);
		if (ready_hold > 0) begin
			ready_hold--;
			if (ready_hold == 0)
				rsp_ready <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			ready_hold = $urandom_range(1, 4);
			rsp_ready <= 1'b0;
		end
	end

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0:       v = 32'h8000_0000;
			1:       v = 32'h7FFF_FFFF;
			2:       v = $urandom_range(0, 15);
			3:       v = 32'h0 - $urandom_range(1, 16);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_cmd(input logic [1:0] act, input logic [31:0] val);
		int   gap;
		cmd_t c;
		if (items_sent >= calm_mark)
			calm = 1'b1;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		c.action     = act;
		c.item_value = val;
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_cmd(c);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	initial begin
		int          random_start;
		int          phase;
		int          kind;
		int          fills;
		int          len;
		int          r;
		logic [31:0] pool [6];
		logic [31:0] last_added;

		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		rsp_ready <= 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty dump, extreme values, removal of middle, tail and first
		// nodes, duplicates from plain append, clear and the single-element list.
		send_cmd(ACT_DUMP,   32'h0000_0000);
		send_cmd(ACT_TOGGLE, 32'h8000_0000);
		send_cmd(ACT_TOGGLE, 32'h7FFF_FFFF);
		send_cmd(ACT_TOGGLE, 32'h0000_0000);
		send_cmd(ACT_TOGGLE, 32'hFFFF_FFFF);
		send_cmd(ACT_DUMP,   32'hFFFF_FFFF);
		send_cmd(ACT_TOGGLE, 32'h7FFF_FFFF);
		send_cmd(ACT_TOGGLE, 32'hFFFF_FFFF);
		send_cmd(ACT_APPEND, 32'h5555_AAAA);
		send_cmd(ACT_TOGGLE, 32'h8000_0000);
		send_cmd(ACT_APPEND, 32'h0000_0000);
		send_cmd(ACT_DUMP,   32'h1234_5678);
		send_cmd(ACT_TOGGLE, 32'h0000_0000);
		send_cmd(ACT_DUMP,   32'h0000_0000);
		send_cmd(ACT_CLEAR,  32'hA5A5_A5A5);
		send_cmd(ACT_DUMP,   32'h5A5A_5A5A);
		send_cmd(ACT_APPEND, 32'h1234_5678);
		send_cmd(ACT_TOGGLE, 32'h1234_5678);
		send_cmd(ACT_DUMP,   32'hFFFF_FFFF);
		send_cmd(ACT_APPEND, 32'hFFFF_FFFF);
		send_cmd(ACT_APPEND, 32'h8000_0000);
		send_cmd(ACT_DUMP,   32'h0000_0000);
		send_cmd(ACT_CLEAR,  32'h0000_0000);

		random_start = items_sent;
		calm_mark    = random_start + CALM_FROM;
		phase        = 0;
		fills        = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			kind = (phase == 1) ? 5 : $urandom_range(0, 9);
			if (kind == 5 && fills >= MAX_FILLS)
				kind = 7;
			if (kind <= 4) begin
				// Mostly toggles over a small pool so that values come and go, with some appends, dumps and clears.
				foreach (pool[i]) pool[i] = pick_value();
				len = $urandom_range(10, 30);
				repeat (len) begin
					r = $urandom_range(0, 19);
					if (r < 14)
						send_cmd(ACT_TOGGLE, pool[$urandom_range(0, 5)]);
					else if (r < 16)
						send_cmd(ACT_APPEND, pool[$urandom_range(0, 5)]);
					else if (r < 18)
						send_cmd(ACT_DUMP, $urandom);
					else if (r == 18)
						send_cmd(ACT_TOGGLE, pick_value());
					else
						send_cmd(ACT_CLEAR, $urandom);
				end
				send_cmd(ACT_DUMP, $urandom);
			end else if (kind <= 6) begin
				// Fill the store past its capacity, then work at the full list.
				fills++;
				send_cmd(ACT_CLEAR, $urandom);
				last_added = '0;
				repeat (SLOTS) begin
					r = $urandom_range(0, 1);
					if (sb.free_slot != '0)
						last_added = $urandom;
					send_cmd(r ? ACT_APPEND : ACT_TOGGLE, last_added);
				end
				send_cmd(ACT_DUMP, $urandom);
				send_cmd(ACT_TOGGLE, $urandom);
				send_cmd(ACT_TOGGLE, last_added);
				send_cmd(ACT_APPEND, $urandom);
				send_cmd(ACT_DUMP, $urandom);
				send_cmd(ACT_CLEAR, $urandom);
			end else begin
				len = $urandom_range(5, 15);
				repeat (len)
					send_cmd(2'($urandom_range(0, 3)), pick_value());
			end
			if (phase == 0 || (!calm && $urandom_range(0, 2) == 0))
				hold_until_drained();
			phase++;
		end

		cmd_valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.expected.size() == 0) begin
			$display("static_list_symmetric_difference: match");
		end else begin
			$display("static_list_symmetric_difference: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/slsd_pkg.sv
hw/rtl/slsd_useq.sv
hw/rtl/slsd_dpath.sv
hw/rtl/static_list_symmetric_difference.sv
test/static_list_symmetric_difference_test.sv
